FILE: design/pft_pkg.sv
// Shared types and constants for the pose frame transform pipeline.
// Used by every module of the block; no dependencies.
package pft_pkg;

  localparam int CordicStagesDef = 16;
  localparam int CW = 34;

  localparam logic signed [CW-1:0] XInit = CW'(32'sh26DD3B6A);

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic               action;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
  } pft_in_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [15:0] heading_out;
  } pft_out_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [15:0] heading;
    logic               flip;
  } pft_side_t;

endpackage

FILE: design/pft_prep.sv
// Angle preparation stage: heading negate, half-turn fold, CORDIC angle.
// Depends on pft_pkg.
module pft_prep
  import pft_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  pft_in_t              data_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] z_o,
  output pft_side_t            side_o
);

  logic signed [15:0]   a16;
  logic signed [16:0]   a17;
  logic signed [16:0]   af;
  logic                 flip;
  logic signed [CW-1:0] z_d;
  logic signed [CW-1:0] z_q;
  pft_side_t            side_d;
  pft_side_t            side_q;
  logic                 valid_q;

  always_comb begin
    a16 = data_i.action ? 16'(16'sd0 - data_i.pose_heading) : data_i.pose_heading;
    a17 = 17'(a16);
    flip = 1'b0;
    af = a17;
    if (a16 > 16'sd16384) begin
      af = a17 - 17'sd32768;
      flip = 1'b1;
    end else if (a16 < -16'sd16384) begin
      af = a17 + 17'sd32768;
      flip = 1'b1;
    end
    z_d = CW'(af) <<< 16;
    side_d.pose_x  = data_i.pose_x;
    side_d.pose_y  = data_i.pose_y;
    side_d.vec_x   = data_i.vec_x;
    side_d.vec_y   = data_i.vec_y;
    side_d.heading = data_i.pose_heading;
    side_d.flip    = flip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q    <= z_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

FILE: design/pft_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, side data carried along.
// Depends on pft_pkg.
module pft_cordic
  import pft_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] z_i,
  input  pft_side_t            side_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o,
  output pft_side_t            side_o
);

  logic signed [CW-1:0] x_q [CORDIC_STAGES];
  logic signed [CW-1:0] y_q [CORDIC_STAGES];
  logic signed [CW-1:0] z_q [CORDIC_STAGES];
  pft_side_t            side_q [CORDIC_STAGES];
  logic                 v_q [CORDIC_STAGES];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    localparam logic signed [CW-1:0] At = CW'(ATAN_TAB[k]);
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [CW-1:0] zi;
    pft_side_t            si;
    logic                 vi;
    logic signed [CW-1:0] x_d;
    logic signed [CW-1:0] y_d;
    logic signed [CW-1:0] z_d;

    if (k == 0) begin : g_first
      assign xi = XInit;
      assign yi = '0;
      assign zi = z_i;
      assign si = side_i;
      assign vi = valid_i;
    end else begin : g_next
      assign xi = x_q[k-1];
      assign yi = y_q[k-1];
      assign zi = z_q[k-1];
      assign si = side_q[k-1];
      assign vi = v_q[k-1];
    end

    always_comb begin
      if (!zi[CW-1]) begin
        x_d = xi - (yi >>> k);
        y_d = yi + (xi >>> k);
        z_d = zi - At;
      end else begin
        x_d = xi + (yi >>> k);
        y_d = yi - (xi >>> k);
        z_d = zi + At;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        side_q[k] <= si;
      end
    end
  end

  assign valid_o = v_q[CORDIC_STAGES-1];
  assign cos_o   = x_q[CORDIC_STAGES-1];
  assign sin_o   = y_q[CORDIC_STAGES-1];
  assign side_o  = side_q[CORDIC_STAGES-1];

endmodule

FILE: design/pft_mix.sv
// Back end: sign fix, four products, rounded saturated rotation, offset sum.
// Depends on pft_pkg; the last register is the output register.
module pft_mix
  import pft_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] cos_i,
  input  logic signed [CW-1:0] sin_i,
  input  pft_side_t            side_i,
  output logic                 valid_o,
  output pft_out_t             data_o
);

  localparam logic signed [65:0] Rnd    = 66'sd536870912;
  localparam logic signed [31:0] MaxVal = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MinVal = 32'sh80000000;

  // sign fix stage
  logic               vf_q;
  logic signed [31:0] c_q;
  logic signed [31:0] s_q;
  pft_side_t          sf_q;

  // product stage
  logic               vm_q;
  logic signed [63:0] pxc_q;
  logic signed [63:0] pys_q;
  logic signed [63:0] pxs_q;
  logic signed [63:0] pyc_q;
  pft_side_t          sm_q;

  // rotation stage
  logic               vr_q;
  logic signed [31:0] rx_q;
  logic signed [31:0] ry_q;
  logic signed [31:0] rx_d;
  logic signed [31:0] ry_d;
  pft_side_t          sr_q;

  // output stage
  logic               vo_q;
  pft_out_t           out_d;
  pft_out_t           out_q;

  logic signed [65:0] sum_x;
  logic signed [65:0] sum_y;
  logic signed [65:0] sh_x;
  logic signed [65:0] sh_y;
  logic signed [32:0] off_x;
  logic signed [32:0] off_y;

  always_comb begin
    sum_x = 66'(pxc_q) - 66'(pys_q) + Rnd;
    sum_y = 66'(pxs_q) + 66'(pyc_q) + Rnd;
    sh_x  = sum_x >>> 30;
    sh_y  = sum_y >>> 30;
    if (sh_x > 66'(MaxVal)) begin
      rx_d = MaxVal;
    end else if (sh_x < 66'(MinVal)) begin
      rx_d = MinVal;
    end else begin
      rx_d = sh_x[31:0];
    end
    if (sh_y > 66'(MaxVal)) begin
      ry_d = MaxVal;
    end else if (sh_y < 66'(MinVal)) begin
      ry_d = MinVal;
    end else begin
      ry_d = sh_y[31:0];
    end
  end

  always_comb begin
    off_x = 33'(sr_q.pose_x) + 33'(rx_q);
    off_y = 33'(sr_q.pose_y) + 33'(ry_q);
    out_d.rot_x       = rx_q;
    out_d.rot_y       = ry_q;
    out_d.heading_out = sr_q.heading;
    if (off_x[32] != off_x[31]) begin
      out_d.offset_x = off_x[32] ? MinVal : MaxVal;
    end else begin
      out_d.offset_x = off_x[31:0];
    end
    if (off_y[32] != off_y[31]) begin
      out_d.offset_y = off_y[32] ? MinVal : MaxVal;
    end else begin
      out_d.offset_y = off_y[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vm_q <= 1'b0;
      vr_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= valid_i;
      vm_q <= vf_q;
      vr_q <= vm_q;
      vo_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= 32'(side_i.flip ? -cos_i : cos_i);
      s_q   <= 32'(side_i.flip ? -sin_i : sin_i);
      sf_q  <= side_i;
      pxc_q <= 64'(sf_q.vec_x) * 64'(c_q);
      pys_q <= 64'(sf_q.vec_y) * 64'(s_q);
      pxs_q <= 64'(sf_q.vec_x) * 64'(s_q);
      pyc_q <= 64'(sf_q.vec_y) * 64'(c_q);
      sm_q  <= sf_q;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      sr_q  <= sm_q;
      out_q <= out_d;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule

FILE: design/pose_frame_transform_top.sv
// Pose frame transform: an accepted beat passes the prep register, the CORDIC
// stages and the pft_mix registers; one beat per cycle sustained while
// out_stall_i is low. One register stage per CORDIC iteration sets the depth;
// a skid register on the input keeps in_stall_o registered.
// Reset clears all valid bits and skid_full_q, not skid_q or any data register.
// Depends on pft_pkg, pft_prep, pft_cordic, pft_mix.
module pose_frame_transform_top
  import pft_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pft_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pft_out_t out_data_o
);

  logic                 adv;
  logic                 skid_full_q;
  logic                 skid_full_d;
  pft_in_t              skid_q;
  logic                 pipe_valid;
  pft_in_t              pipe_data;
  logic                 prep_valid;
  logic signed [CW-1:0] prep_z;
  pft_side_t            prep_side;
  logic                 cor_valid;
  logic signed [CW-1:0] cor_cos;
  logic signed [CW-1:0] cor_sin;
  pft_side_t            cor_side;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = skid_full_q;
  assign pipe_valid = skid_full_q ? 1'b1 : in_valid_i;
  assign pipe_data  = skid_full_q ? skid_q : in_data_i;

  always_comb begin
    skid_full_d = skid_full_q;
    if (adv) begin
      skid_full_d = 1'b0;
    end else if (in_valid_i && !skid_full_q) begin
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  // hold a beat that arrives while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (!adv && in_valid_i && !skid_full_q) begin
      skid_q <= in_data_i;
    end
  end

  pft_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pipe_valid),
    .data_i  (pipe_data),
    .valid_o (prep_valid),
    .z_o     (prep_z),
    .side_o  (prep_side)
  );

  pft_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (prep_valid),
    .z_i     (prep_z),
    .side_i  (prep_side),
    .valid_o (cor_valid),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin),
    .side_o  (cor_side)
  );

  pft_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (cor_valid),
    .cos_i   (cor_cos),
    .sin_i   (cor_sin),
    .side_i  (cor_side),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !adv) |=> skid_full_q)
    else $error("stalled input beat not captured in skid register");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && !adv) |=> (skid_full_q && $stable(skid_q)))
    else $error("skid register lost or changed a held beat");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && adv) |=> !skid_full_q)
    else $error("skid register not drained on advance");

endmodule

FILE: sim/tb_pose_frame_transform_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for pose_frame_transform_top: directed table, then random beats.
// Uses pft_pkg types and a local CORDIC transform predictor; needs only the RTL.
module tb_pose_frame_transform_top;
  import pft_pkg::*;

  localparam int Stages = CordicStagesDef;
  localparam int RandPerPhase = 477;
  localparam int HoldCycles = 400;
  localparam int IdleLimit = 2000;
  localparam int NumRows = 22;
  localparam longint RoundHalf = 64'sd536870912;

  localparam logic signed [31:0] QMax = 32'sh7FFFFFFF;
  localparam logic signed [31:0] QMin = 32'sh80000000;
  localparam logic signed [31:0] QOne = 32'sh00010000;
  localparam logic signed [31:0] QNegOne = 32'shFFFF0000;
  localparam logic signed [31:0] QHalf = 32'sh00008000;

  typedef struct packed {
    pft_in_t  beat;
    logic     typed;
    pft_out_t result;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [NumRows] = '{
    '{'{1'b0, 32'sh0, 32'sh0, 16'sh0000, 32'sh0, 32'sh0}, 1'b1,
      '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 16'sh0000}},
    '{'{1'b1, QMax, QMax, 16'sh8000, 32'sh0, 32'sh0}, 1'b1,
      '{32'sh0, 32'sh0, QMax, QMax, 16'sh8000}},
    '{'{1'b0, QMin, QMin, 16'sh7FFF, 32'sh0, 32'sh0}, 1'b1,
      '{32'sh0, 32'sh0, QMin, QMin, 16'sh7FFF}},
    '{'{1'b1, QMax, QMin, 16'sh4000, 32'sh0, 32'sh0}, 1'b1,
      '{32'sh0, 32'sh0, QMax, QMin, 16'sh4000}},
    '{'{1'b0, 32'sh0, 32'sh0, 16'sh0000, QOne, 32'sh0}, 1'b0, '0},
    '{'{1'b1, 32'sh0, 32'sh0, 16'sh0000, QOne, QOne}, 1'b0, '0},
    '{'{1'b0, 32'sh0, 32'sh0, 16'sh4000, QOne, 32'sh0}, 1'b0, '0},
    '{'{1'b0, 32'sh0, 32'sh0, 16'shC000, QOne, 32'sh0}, 1'b0, '0},
    '{'{1'b0, 32'sh0, 32'sh0, 16'sh4001, QOne, QHalf}, 1'b0, '0},
    '{'{1'b0, 32'sh0, 32'sh0, 16'shBFFF, QOne, QHalf}, 1'b0, '0},
    '{'{1'b1, 32'sh0, 32'sh0, 16'sh4001, QOne, QHalf}, 1'b0, '0},
    '{'{1'b1, 32'sh0, 32'sh0, 16'shBFFF, QOne, QHalf}, 1'b0, '0},
    '{'{1'b0, QOne, QOne, 16'sh8000, QOne, QOne}, 1'b0, '0},
    '{'{1'b1, QOne, QOne, 16'sh8000, QOne, QOne}, 1'b0, '0},
    '{'{1'b0, 32'sh0, 32'sh0, 16'sh7FFF, QMax, QMin}, 1'b0, '0},
    '{'{1'b1, 32'sh0, 32'sh0, 16'sh8001, QMin, QMax}, 1'b0, '0},
    '{'{1'b0, 32'sh0, 32'sh0, 16'sh2000, QMax, QMax}, 1'b0, '0},
    '{'{1'b1, 32'sh0, 32'sh0, 16'sh2000, QMin, QMin}, 1'b0, '0},
    '{'{1'b0, QMax, QMax, 16'sh0000, QOne, QOne}, 1'b0, '0},
    '{'{1'b1, QMin, QMin, 16'sh0000, QNegOne, QNegOne}, 1'b0, '0},
    '{'{1'b0, 32'sh0, 32'sh0, 16'sh6000, 32'shFFFFFFFF, 32'shFFFFFFFF}, 1'b0, '0},
    '{'{1'b1, 32'sh12345678, 32'shEDCBA988, 16'shE000, 32'sh00018000, 32'shFFFE8000},
      1'b0, '0}
  };

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  pft_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pft_out_t out_data_o;

  pft_out_t pending_transforms [$];
  int       mismatches = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  logic     hold_req = 1'b0;
  logic     hold_ack = 1'b0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  pose_frame_transform_top #(
    .CORDIC_STAGES(Stages)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(QMax)) return QMax;
    if (v < longint'(QMin)) return QMin;
    return v[31:0];
  endfunction

  function automatic pft_out_t transform_point(pft_in_t b);
    logic signed [15:0] ang;
    longint a, x, y, z, t, vx, vy;
    bit flip;
    pft_out_t r;
    ang = b.action ? -b.pose_heading : b.pose_heading;
    a = longint'(ang);
    flip = 1'b0;
    if (a > 16384) begin
      a -= 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1'b1;
    end
    z = a * 65536;
    x = 64'sh26DD3B6A;
    y = '0;
    for (int i = 0; i < Stages; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'({32'd0, ATAN_TAB[i]});
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'({32'd0, ATAN_TAB[i]});
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    vx = longint'(b.vec_x);
    vy = longint'(b.vec_y);
    r.rot_x = sat32((vx * x - vy * y + RoundHalf) >>> 30);
    r.rot_y = sat32((vx * y + vy * x + RoundHalf) >>> 30);
    r.offset_x = sat32(longint'(b.pose_x) + longint'(r.rot_x));
    r.offset_y = sat32(longint'(b.pose_y) + longint'(r.rot_y));
    r.heading_out = b.pose_heading;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(3))
          0: return QMax;
          1: return QMin;
          2: return 32'sh0;
          default: return 32'shFFFFFFFF;
        endcase
      end
      default: return 32'($urandom_range(24'hFFFFFF)) - 32'h00800000;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_heading();
    if ($urandom_range(7) != 0) return 16'($urandom());
    case ($urandom_range(7))
      0: return 16'sh4000;
      1: return 16'shC000;
      2: return 16'sh4001;
      3: return 16'shBFFF;
      4: return 16'sh8000;
      5: return 16'sh7FFF;
      6: return 16'sh0000;
      default: return 16'sh8001;
    endcase
  endfunction

  function automatic pft_in_t random_beat();
    pft_in_t b;
    b.action = 1'($urandom_range(1));
    b.pose_x = pick_coord();
    b.pose_y = pick_coord();
    b.pose_heading = pick_heading();
    b.vec_x = pick_coord();
    b.vec_y = pick_coord();
    return b;
  endfunction

  task automatic send_beat(input pft_in_t beat, input logic typed, input pft_out_t result);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_transforms.push_back(typed ? result : transform_point(beat));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_transforms.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result(input pft_out_t got);
    pft_out_t want;
    if (pending_transforms.size() == 0) begin
      $error("unexpected result beat: rot_x %0d rot_y %0d", got.rot_x, got.rot_y);
      mismatches++;
      return;
    end
    want = pending_transforms.pop_front();
    if (got.rot_x !== want.rot_x) begin
      $error("rot_x: expected %0d, actual %0d", want.rot_x, got.rot_x);
      mismatches++;
    end
    if (got.rot_y !== want.rot_y) begin
      $error("rot_y: expected %0d, actual %0d", want.rot_y, got.rot_y);
      mismatches++;
    end
    if (got.offset_x !== want.offset_x) begin
      $error("offset_x: expected %0d, actual %0d", want.offset_x, got.offset_x);
      mismatches++;
    end
    if (got.offset_y !== want.offset_y) begin
      $error("offset_y: expected %0d, actual %0d", want.offset_y, got.offset_y);
      mismatches++;
    end
    if (got.heading_out !== want.heading_out) begin
      $error("heading_out: expected %0d, actual %0d", want.heading_out, got.heading_out);
      mismatches++;
    end
  endtask

  // Check accepted result beats; hold off on request, else stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if (hold_req != hold_ack) begin
        hold_ack    <= hold_req;
        hold_left   <= HoldCycles;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 19;
    rx_idle_pct <= 86;
    for (int r = 0; r < NumRows; r++) begin
      send_beat(DIR_TABLE[r].beat, DIR_TABLE[r].typed, DIR_TABLE[r].result);
    end
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct <= 86;
        end
        1: begin
          tx_idle_pct = 86;
          rx_idle_pct <= 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        if (phase == 0 && n == 150) hold_req <= ~hold_req;
        if (phase == 1 && n == 200) drain_results();
        if (phase == 2 && n == 100) hold_req <= ~hold_req;
        send_beat(random_beat(), 1'b0, '0);
      end
    end
    drain_results();
    repeat (Stages + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
